@@ rtl/aisl_pkg.sv @@
package aisl_pkg;

  localparam int unsigned PageBytes   = 4096;
  localparam int unsigned HeaderBytes = 32;
  localparam int unsigned HdrCntW     = $clog2(HeaderBytes + 1);
  localparam int unsigned HdrIdxW     = $clog2(HeaderBytes);
  localparam int unsigned QDepth      = 2;
  localparam int unsigned QPtrW       = $clog2(QDepth);
  localparam int unsigned QCntW       = $clog2(QDepth + 1);

  localparam logic [31:0] PageMask   = 32'(PageBytes - 1);
  localparam logic [31:0] SkipReset  = 32'(PageBytes);
  localparam logic [15:0] MagicValue = 16'h010B;

  typedef enum logic [1:0] {
    KindWrite = 2'd0,
    KindBss   = 2'd1,
    KindStart = 2'd2,
    KindBad   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] address;
    logic [31:0] value;
    logic [31:0] entry_point;
    logic        last;
  } result_t;

  // at most one command per byte; more adds a trailing start after a write
  typedef struct packed {
    kind_e       kind;
    logic [31:0] address;
    logic [31:0] value;
    logic [31:0] entry;
    logic        more;
  } cmd_t;

  function automatic logic [31:0] page_round(input logic [31:0] a);
    return (a + PageMask) & ~PageMask;
  endfunction

endpackage

@@ rtl/aisl_front.sv @@
module aisl_front import aisl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  accept_i,
  input  item_t item_i,
  output logic  cmd_valid_o,
  output cmd_t  cmd_o
);

  logic [HdrCntW-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [7:0]         hdr_q [HeaderBytes];
  logic               seg_data_q, seg_data_d;
  logic [31:0]        skip_q, skip_d;
  logic [31:0]        bytes_q, bytes_d;
  logic [31:0]        wa_q, wa_d;
  logic               finished_q, finished_d;

  logic [15:0] magic;
  logic [31:0] word1, word2, word3, word5;
  logic        hdr_done, hdr_last;

  assign magic    = {hdr_q[1], hdr_q[0]};
  assign word1    = {hdr_q[7], hdr_q[6], hdr_q[5], hdr_q[4]};
  assign word2    = {hdr_q[11], hdr_q[10], hdr_q[9], hdr_q[8]};
  assign word3    = {hdr_q[15], hdr_q[14], hdr_q[13], hdr_q[12]};
  assign word5    = {hdr_q[23], hdr_q[22], hdr_q[21], hdr_q[20]};
  assign hdr_done = (hdr_cnt_q == HdrCntW'(HeaderBytes));
  assign hdr_last = (hdr_cnt_q == HdrCntW'(HeaderBytes - 1));

  always_comb begin
    logic [31:0] al;
    logic [31:0] gap;
    logic        wrote;
    logic        done;
    hdr_cnt_d   = hdr_cnt_q;
    seg_data_d  = seg_data_q;
    skip_d      = skip_q;
    bytes_d     = bytes_q;
    wa_d        = wa_q;
    finished_d  = finished_q;
    cmd_valid_o = 1'b0;
    cmd_o       = '{kind: KindBad, address: '0, value: '0, entry: '0, more: 1'b0};
    al          = page_round(wa_q);
    gap         = al - wa_q;
    wrote       = 1'b0;
    done        = 1'b0;
    if (accept_i && !finished_q) begin
      if (!hdr_done) begin
        hdr_cnt_d = hdr_cnt_q + 1'b1;
        if (skip_q != '0) begin
          skip_d = skip_q - 1'b1;
        end
        if (hdr_last) begin
          if (magic != MagicValue) begin
            cmd_valid_o = 1'b1;
            finished_d  = 1'b1;
          end else begin
            wa_d    = word5;
            bytes_d = word1;
            if (item_i.end_of_file) begin
              cmd_valid_o = 1'b1;
              cmd_o.kind  = KindStart;
              cmd_o.entry = word5;
              finished_d  = 1'b1;
            end
          end
        end else if (item_i.end_of_file) begin
          cmd_valid_o = 1'b1;
          finished_d  = 1'b1;
        end
      end else begin
        if (skip_q != '0) begin
          skip_d = skip_q - 1'b1;
        end else if (bytes_q != '0) begin
          wrote         = 1'b1;
          cmd_o.address = wa_q;
          wa_d          = wa_q + 1'b1;
          bytes_d       = bytes_q - 1'b1;
        end else if (!seg_data_q) begin
          seg_data_d = 1'b1;
          if (gap != '0) begin
            skip_d  = gap - 1'b1;
            wa_d    = al;
            bytes_d = word2;
          end else if (word2 != '0) begin
            wrote         = 1'b1;
            cmd_o.address = al;
            wa_d          = al + 1'b1;
            bytes_d       = word2 - 1'b1;
          end else begin
            done          = 1'b1;
            cmd_o.address = al;
          end
        end else begin
          done          = 1'b1;
          cmd_o.address = al;
        end
        if (done) begin
          cmd_valid_o = 1'b1;
          cmd_o.kind  = KindBss;
          cmd_o.value = word3;
          cmd_o.entry = word5;
          finished_d  = 1'b1;
          wa_d        = al;
        end else if (wrote) begin
          cmd_valid_o = 1'b1;
          cmd_o.kind  = KindWrite;
          cmd_o.value = {24'd0, item_i.data_byte};
          if (item_i.end_of_file) begin
            cmd_o.entry = word5;
            cmd_o.more  = 1'b1;
            finished_d  = 1'b1;
          end
        end else if (item_i.end_of_file) begin
          cmd_valid_o   = 1'b1;
          cmd_o.kind    = KindStart;
          cmd_o.address = '0;
          cmd_o.entry   = word5;
          finished_d    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q  <= '0;
      seg_data_q <= 1'b0;
      skip_q     <= SkipReset;
      bytes_q    <= '0;
      wa_q       <= '0;
      finished_q <= 1'b0;
    end else begin
      hdr_cnt_q  <= hdr_cnt_d;
      seg_data_q <= seg_data_d;
      skip_q     <= skip_d;
      bytes_q    <= bytes_d;
      wa_q       <= wa_d;
      finished_q <= finished_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && !finished_q && !hdr_done) begin
      hdr_q[hdr_cnt_q[HdrIdxW-1:0]] <= item_i.data_byte;
    end
  end

endmodule

@@ rtl/aisl_fifo.sv @@
module aisl_fifo import aisl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  cmd_t wr_data_i,
  output logic full_o,
  input  logic rd_en_i,
  output logic empty_o,
  output cmd_t rd_data_o
);

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o    = (cnt_q == QCntW'(QDepth));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_en_i && !rd_en_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!wr_en_i && rd_en_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ rtl/aisl_back.sv @@
module aisl_back import aisl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_empty_i,
  input  cmd_t    q_data_i,
  output logic    q_pop_o,
  output logic    empty_o,
  input  logic    pop_i,
  output result_t result_o
);

  cmd_t cur_q;
  logic cur_valid_q;
  logic tail_q;
  logic xfer, retire, load;

  assign xfer    = pop_i && cur_valid_q;
  assign retire  = xfer && (tail_q || !cur_q.more);
  assign load    = !cur_valid_q || retire;
  assign q_pop_o = load && !q_empty_i;
  assign empty_o = !cur_valid_q;

  always_comb begin
    if (tail_q) begin
      result_o = '{kind: KindStart, address: '0, value: '0,
                   entry_point: cur_q.entry, last: 1'b1};
    end else begin
      result_o = '{kind: cur_q.kind, address: cur_q.address, value: cur_q.value,
                   entry_point: cur_q.more ? '0 : cur_q.entry, last: !cur_q.more};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      tail_q      <= 1'b0;
    end else begin
      if (load) begin
        cur_valid_q <= !q_empty_i;
        tail_q      <= 1'b0;
      end else if (xfer) begin
        tail_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_data_i;
    end
  end

endmodule

@@ rtl/aout_image_stream_loader_core.sv @@
// Streaming a.out boot image loader.
// Input queue side: one image byte per transfer on item_i (push/full), with
// end_of_file marking the last byte. Result queue side: result_o is valid
// while empty is low and is taken with pop.
// The first 32 bytes are the header; a bad magic or an early end of file
// gives one bad-image result. Text bytes from file offset 4096 and then
// page-aligned data bytes each give one write result; the next byte gives
// the clear-bss-and-start command, and an earlier end of file a plain start.
// Once finished, further bytes are taken and dropped until reset.
// Throughput: one byte per cycle while full is low. A byte's results pass
// through the command queue into the output register; a write on the
// last byte adds a start result, presented after the write is taken.
// The front tracker feeds a two-entry command queue; full rises only when
// that queue fills, so a stalled receiver holds back input after two
// pending commands plus the one on the output.
// Reset (rst_ni low, asynchronous) clears all tracking state and both queues.
module aout_image_stream_loader_core import aisl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push,
  output logic    full,
  input  item_t   item_i,
  output logic    empty,
  input  logic    pop,
  output result_t result_o
);

  logic cmd_valid;
  cmd_t cmd;
  logic q_pop, q_empty;
  cmd_t q_data;

  aisl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (push && !full),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  aisl_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cmd_valid),
    .wr_data_i (cmd),
    .full_o    (full),
    .rd_en_i   (q_pop),
    .empty_o   (q_empty),
    .rd_data_o (q_data)
  );

  aisl_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .result_o  (result_o)
  );

endmodule

@@ tb/sv/aout_image_stream_loader_core_test.sv @@
module aout_image_stream_loader_core_test import aisl_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned StallAt     = 40;
  localparam int unsigned StallCycles = 120;
  localparam int unsigned TailCycles  = 20;
  localparam int unsigned NoiseBytes  = 12;

  localparam logic [1:0] SegText = 2'd0;
  localparam logic [1:0] SegData = 2'd1;
  localparam logic [1:0] SegBss  = 2'd2;

  localparam int unsigned EndOnWrite  = 0;
  localparam int unsigned EndOnBssEof = 1;
  localparam int unsigned EndOnBss    = 2;

  typedef struct {
    item_t payload;
    bit    drain;
  } image_byte_t;

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  logic    push   = 1'b0;
  logic    full;
  item_t   item_i = '0;
  logic    empty;
  logic    pop    = 1'b0;
  result_t result_o;

  image_byte_t image_bytes[$];
  result_t     loader_cmds[$];

  // loader tracking state
  int unsigned hdr_count;
  logic [31:0] hdr_words [8];
  logic [1:0]  segment;
  logic [31:0] skip_left;
  logic [31:0] bytes_left;
  logic [31:0] wr_addr;
  bit          image_done;

  int unsigned errors;
  int unsigned bytes_sent;
  int unsigned cmds_checked;
  int unsigned writes_checked;
  int unsigned full_stalls;
  int unsigned tx_gap;
  int unsigned tx_burst;
  int unsigned rx_gap;
  int unsigned rx_burst;
  int unsigned idle_cycles;
  bit          rx_stalled;
  kind_e       last_kind = KindWrite;

  aout_image_stream_loader_core dut (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .item_i,
    .empty,
    .pop,
    .result_o
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic result_t make_cmd(kind_e k, logic [31:0] a, logic [31:0] v,
                                       logic [31:0] e);
    result_t r;
    r.kind        = k;
    r.address     = a;
    r.value       = v;
    r.entry_point = e;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic logic [31:0] align_up(logic [31:0] a);
    logic [31:0] rem;
    rem = a % PageBytes;
    return (rem == 0) ? a : a + (PageBytes - rem);
  endfunction

  task automatic load_byte(input item_t it);
    result_t     batch[$];
    bit          used;
    int unsigned idx;
    int unsigned step;
    if (image_done) return;
    if (hdr_count < HeaderBytes) begin
      idx = hdr_count;
      hdr_words[idx / 4][8 * (idx % 4) +: 8] = it.data_byte;
      hdr_count++;
      if (skip_left != 0) skip_left--;
      if (hdr_count == HeaderBytes) begin
        if (hdr_words[0][15:0] != MagicValue) begin
          batch.push_back(make_cmd(KindBad, 0, 0, 0));
          image_done = 1'b1;
        end else begin
          wr_addr    = hdr_words[5];
          bytes_left = hdr_words[1];
          if (it.end_of_file) begin
            batch.push_back(make_cmd(KindStart, 0, 0, hdr_words[5]));
            image_done = 1'b1;
          end
        end
      end else if (it.end_of_file) begin
        batch.push_back(make_cmd(KindBad, 0, 0, 0));
        image_done = 1'b1;
      end
    end else begin
      used = 1'b0;
      // a run-out segment switches on the byte that follows it
      for (step = 0; step < 3 && !used && !image_done; step++) begin
        if (skip_left != 0) begin
          skip_left--;
          used = 1'b1;
        end else if (bytes_left != 0) begin
          batch.push_back(make_cmd(KindWrite, wr_addr, {24'd0, it.data_byte}, 0));
          wr_addr++;
          bytes_left--;
          used = 1'b1;
        end else if (segment == SegText) begin
          segment    = SegData;
          skip_left  = align_up(wr_addr) - wr_addr;
          wr_addr    = align_up(wr_addr);
          bytes_left = hdr_words[2];
        end else begin
          segment = SegBss;
          wr_addr = align_up(wr_addr);
          batch.push_back(make_cmd(KindBss, wr_addr, hdr_words[3], hdr_words[5]));
          image_done = 1'b1;
        end
      end
      if (it.end_of_file && !image_done) begin
        batch.push_back(make_cmd(KindStart, 0, 0, hdr_words[5]));
        image_done = 1'b1;
      end
    end
    if (batch.size() != 0) begin
      batch[batch.size() - 1].last = 1'b1;
      last_kind = batch[batch.size() - 1].kind;
      foreach (batch[i]) loader_cmds.push_back(batch[i]);
    end
  endtask

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", fname, want, got);
      errors++;
    end
  endfunction

  function automatic int unsigned draw_gap(inout int unsigned burst);
    if (burst != 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 3);
  endfunction

  function automatic void queue_byte(logic [7:0] b, bit eof, bit drain);
    image_byte_t p;
    p.payload.data_byte   = b;
    p.payload.end_of_file = eof;
    p.drain               = drain;
    image_bytes.push_back(p);
  endfunction

  // byte sender
  always @(posedge clk_i) begin
    bit offering;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      offering = push;
      if (push && !full) begin
        load_byte(item_i);
        bytes_sent++;
        offering = 1'b0;
        tx_gap   = draw_gap(tx_burst);
      end else if (push && full) begin
        full_stalls++;
      end
      if (!offering) begin
        if (tx_gap != 0) begin
          tx_gap--;
        end else if (image_bytes.size() != 0 &&
                     (!image_bytes[0].drain || loader_cmds.size() == 0)) begin
          item_i <= image_bytes[0].payload;
          void'(image_bytes.pop_front());
          offering = 1'b1;
        end
      end
      push <= offering;
    end
  end

  // command receiver and checker
  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (loader_cmds.size() == 0) begin
          $error("unexpected command transfer: kind %0d", result_o.kind);
          errors++;
        end else begin
          want = loader_cmds.pop_front();
          check_field("kind", 32'(want.kind), 32'(result_o.kind));
          check_field("address", want.address, result_o.address);
          check_field("value", want.value, result_o.value);
          check_field("entry_point", want.entry_point, result_o.entry_point);
          check_field("last", 32'(want.last), 32'(result_o.last));
          cmds_checked++;
          if (want.kind == KindWrite) writes_checked++;
        end
        if (!rx_stalled && cmds_checked == StallAt) begin
          rx_stalled = 1'b1;
          rx_gap     = StallCycles;
        end else begin
          rx_gap = draw_gap(rx_burst);
        end
      end
      if (rx_gap != 0) begin
        rx_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no transfer for %0d cycles", IdleLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] hdr [8];
    logic [31:0] text_len;
    logic [31:0] data_len;
    logic [31:0] entry;
    logic [31:0] pad;
    int unsigned ending;
    int unsigned i;
    int unsigned j;
    logic [7:0]  edge_bytes [4];

    hdr_count  = 0;
    segment    = SegText;
    skip_left  = SkipReset;
    bytes_left = '0;
    wr_addr    = '0;
    image_done = 1'b0;
    foreach (hdr_words[k]) hdr_words[k] = '0;

    case ($urandom_range(0, 2))
      0:       entry = 32'hFFFF_FFFF - $urandom_range(0, 300);
      1:       entry = $urandom & ~PageMask;
      default: entry = $urandom;
    endcase
    text_len = $urandom_range(200, 400);
    data_len = ($urandom_range(0, 7) == 0) ? 32'd0 : 32'($urandom_range(150, 300));
    ending   = $urandom_range(EndOnWrite, EndOnBss);

    hdr[0] = {16'($urandom), MagicValue};
    hdr[1] = text_len;
    hdr[2] = data_len;
    hdr[3] = $urandom;
    hdr[4] = $urandom;
    hdr[5] = entry;
    hdr[6] = $urandom;
    hdr[7] = $urandom;
    for (i = 0; i < 8; i++)
      for (j = 0; j < 4; j++) queue_byte(hdr[i][8 * j +: 8], 1'b0, 1'b0);

    // header bytes count toward the first page skip
    repeat (PageBytes - HeaderBytes) queue_byte(8'($urandom), 1'b0, 1'b0);

    edge_bytes = '{8'h00, 8'hFF, 8'h55, 8'hAA};
    for (i = 0; i < text_len; i++)
      queue_byte((i < 4) ? edge_bytes[i] : 8'($urandom),
                 ending == EndOnWrite && data_len == 0 && i == text_len - 1,
                 i == text_len / 2);

    pad = (32'd0 - (entry + text_len)) & PageMask;
    repeat (pad) queue_byte(8'($urandom), 1'b0, 1'b0);
    for (i = 0; i < data_len; i++)
      queue_byte(8'($urandom), ending == EndOnWrite && i == data_len - 1, 1'b0);
    if (ending != EndOnWrite) queue_byte(8'($urandom), ending == EndOnBssEof, 1'b0);

    // everything past the end is dropped by the loader
    repeat (NoiseBytes) queue_byte(8'($urandom), 1'($urandom), 1'b0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (image_bytes.size() != 0 || push) @(posedge clk_i);
    while (loader_cmds.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (loader_cmds.size() != 0) begin
      $error("%0d commands never arrived", loader_cmds.size());
      errors++;
    end

    $display("Image of %0d bytes: entry %h, %0d text, %0d pad, %0d data bytes, ending %0d.",
             bytes_sent, entry, text_len, pad, data_len, ending);
    $display("Checked %0d commands (%0d writes, final %s); input held off %0d cycles.",
             cmds_checked, writes_checked, last_kind.name(), full_stalls);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/aisl_pkg.sv
rtl/aisl_front.sv
rtl/aisl_fifo.sv
rtl/aisl_back.sv
rtl/aout_image_stream_loader_core.sv
tb/sv/aout_image_stream_loader_core_test.sv
